@@ rtl/core/matrix3x3_arith_unit_macros.svh @@
// Assertion helpers for the 3x3 matrix unit.
// Both take a label, clock, reset, a trigger condition, a check and a message.
`ifndef MATRIX3X3_ARITH_UNIT_MACROS_SVH
`define MATRIX3X3_ARITH_UNIT_MACROS_SVH

// check holds in the same cycle as the trigger
`define M3X3_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check holds in the cycle after the trigger
`define M3X3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/m3x3_pkg.sv @@
package m3x3_pkg;

   // element format and derived widths
   localparam int DATA_WIDTH  = 32;
   localparam int FRAC_BITS   = 16;
   localparam int ELEM_COUNT  = 9;
   localparam int IDX_WIDTH   = 4;
   localparam int OP_WIDTH    = DATA_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * OP_WIDTH;
   // cofactor terms of the determinant: difference of two shifted products
   localparam int T_WIDTH     = 2 * DATA_WIDTH - FRAC_BITS + 1;
   localparam int T_COUNT     = 3;
   localparam int T_ADDR_W    = 2;
   localparam int ACC_WIDTH   = 2 * DATA_WIDTH + 4;

   // stream packing
   localparam int REQ_VALUE_LSB   = IDX_WIDTH;
   localparam int REQ_TDATA_WIDTH = ((IDX_WIDTH + 32 + 7) / 8) * 8;
   localparam int REQ_TUSER_WIDTH = 5;
   localparam int RSP_TDATA_WIDTH = ((DATA_WIDTH + IDX_WIDTH + 7) / 8) * 8;
   localparam int RSP_PAD_WIDTH   = RSP_TDATA_WIDTH - DATA_WIDTH - IDX_WIDTH;

   localparam logic signed [OP_WIDTH-1:0] ONE_OPERAND = OP_WIDTH'(64'd1 << FRAC_BITS);

   typedef enum logic [2:0] {
      FN_ADD,
      FN_SUB,
      FN_MUL,
      FN_SCALE,
      FN_TRANSPOSE,
      FN_DET,
      FN_TRACE
   } func_type;

   typedef enum logic [2:0] {
      SRC_A,
      SRC_B,
      SRC_SCALAR,
      SRC_ONE,
      SRC_TLO,
      SRC_THI
   } src_type;

   typedef enum logic [1:0] {
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH_X,
      ST_FETCH_Y,
      ST_MUL,
      ST_ACC,
      ST_EMIT
   } state_type;

   // one multiply-accumulate step
   typedef struct packed {
      src_type                 x_src;
      logic [IDX_WIDTH-1:0]    x_addr;
      src_type                 y_src;
      logic [IDX_WIDTH-1:0]    y_addr;
      logic                    shift_up;
      acc_op_type              acc_op;
      logic                    t_store;
      logic [T_ADDR_W-1:0]     t_addr;
   } uop_type;

   typedef struct packed {
      logic                    wr_en;
      logic                    wr_b;
      logic [IDX_WIDTH-1:0]    wr_addr;
      logic                    swap;
      logic [IDX_WIDTH-1:0]    rd_addr;
   } store_ctl_type;

   typedef struct packed {
      src_type                 fetch_src;
      logic [IDX_WIDTH-1:0]    fetch_addr;
      logic                    load_x;
      logic                    load_y;
      logic                    mul_en;
      logic                    acc_en;
      logic                    shift_up;
      acc_op_type              acc_op;
      logic                    t_store;
      logic [T_ADDR_W-1:0]     t_addr;
      logic                    scalar_load;
   } mac_ctl_type;

   typedef struct packed {
      logic                    valid;
      logic [IDX_WIDTH-1:0]    index;
      logic                    last;
   } emit_type;

   // row of a column-major position
   function automatic logic [IDX_WIDTH-1:0] elem_row(input logic [IDX_WIDTH-1:0] elem);
      logic [IDX_WIDTH-1:0] row;
      case (elem)
         4'd1, 4'd4, 4'd7: row = 4'd1;
         4'd2, 4'd5, 4'd8: row = 4'd2;
         default:          row = 4'd0;
      endcase
      return row;
   endfunction

   // position of the mirrored element
   function automatic int transpose_pos(input int k);
      return (k % 3) * 3 + (k / 3);
   endfunction

   function automatic logic [IDX_WIDTH-1:0] last_term(input func_type func);
      logic [IDX_WIDTH-1:0] n;
      case (func)
         FN_ADD, FN_SUB: n = 4'd1;
         FN_MUL, FN_TRACE: n = 4'd2;
         FN_DET: n = 4'd11;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [IDX_WIDTH-1:0] last_elem(input func_type func);
      logic [IDX_WIDTH-1:0] n;
      case (func)
         FN_DET, FN_TRACE: n = '0;
         default: n = IDX_WIDTH'(ELEM_COUNT - 1);
      endcase
      return n;
   endfunction

   function automatic uop_type mk_uop(input src_type xs, input logic [IDX_WIDTH-1:0] xa,
                                      input src_type ys, input logic [IDX_WIDTH-1:0] ya,
                                      input logic up, input acc_op_type op,
                                      input logic ts, input logic [T_ADDR_W-1:0] ta);
      uop_type u;
      u.x_src    = xs;
      u.x_addr   = xa;
      u.y_src    = ys;
      u.y_addr   = ya;
      u.shift_up = up;
      u.acc_op   = op;
      u.t_store  = ts;
      u.t_addr   = ta;
      return u;
   endfunction

   // determinant: three cofactors into t, then a0*t0 + a3*t1 + a6*t2,
   // each wide cofactor taken as low word (shifted down) and high part (shifted up)
   function automatic uop_type det_uop(input logic [IDX_WIDTH-1:0] term);
      uop_type u;
      case (term)
         4'd0:  u = mk_uop(SRC_A, 4'd4, SRC_A, 4'd8, 1'b0, ACC_LOAD, 1'b0, 2'd0);
         4'd1:  u = mk_uop(SRC_A, 4'd5, SRC_A, 4'd7, 1'b0, ACC_SUB,  1'b1, 2'd0);
         4'd2:  u = mk_uop(SRC_A, 4'd2, SRC_A, 4'd7, 1'b0, ACC_LOAD, 1'b0, 2'd1);
         4'd3:  u = mk_uop(SRC_A, 4'd1, SRC_A, 4'd8, 1'b0, ACC_SUB,  1'b1, 2'd1);
         4'd4:  u = mk_uop(SRC_A, 4'd1, SRC_A, 4'd5, 1'b0, ACC_LOAD, 1'b0, 2'd2);
         4'd5:  u = mk_uop(SRC_A, 4'd2, SRC_A, 4'd4, 1'b0, ACC_SUB,  1'b1, 2'd2);
         4'd6:  u = mk_uop(SRC_A, 4'd0, SRC_TLO, 4'd0, 1'b0, ACC_LOAD, 1'b0, 2'd0);
         4'd7:  u = mk_uop(SRC_A, 4'd0, SRC_THI, 4'd0, 1'b1, ACC_ADD, 1'b0, 2'd0);
         4'd8:  u = mk_uop(SRC_A, 4'd3, SRC_TLO, 4'd1, 1'b0, ACC_ADD, 1'b0, 2'd0);
         4'd9:  u = mk_uop(SRC_A, 4'd3, SRC_THI, 4'd1, 1'b1, ACC_ADD, 1'b0, 2'd0);
         4'd10: u = mk_uop(SRC_A, 4'd6, SRC_TLO, 4'd2, 1'b0, ACC_ADD, 1'b0, 2'd0);
         4'd11: u = mk_uop(SRC_A, 4'd6, SRC_THI, 4'd2, 1'b1, ACC_ADD, 1'b0, 2'd0);
         default: u = mk_uop(SRC_A, 4'd0, SRC_ONE, 4'd0, 1'b0, ACC_LOAD, 1'b0, 2'd0);
      endcase
      return u;
   endfunction

   // step program of every operation
   function automatic uop_type microcode(input func_type func,
                                         input logic [IDX_WIDTH-1:0] elem,
                                         input logic [IDX_WIDTH-1:0] term);
      uop_type u;
      logic [IDX_WIDTH-1:0] row;
      logic [IDX_WIDTH-1:0] col3;
      acc_op_type op;
      row  = elem_row(elem);
      col3 = elem - row;
      op   = (term == '0) ? ACC_LOAD : ACC_ADD;
      case (func)
         FN_ADD, FN_SUB: begin
            if (term == '0) begin
               u = mk_uop(SRC_A, elem, SRC_ONE, '0, 1'b0, ACC_LOAD, 1'b0, '0);
            end else begin
               u = mk_uop(SRC_B, elem, SRC_ONE, '0, 1'b0,
                          (func == FN_SUB) ? ACC_SUB : ACC_ADD, 1'b0, '0);
            end
         end
         FN_MUL: begin
            u = mk_uop(SRC_A, (term << 1) + term + row, SRC_B, col3 + term,
                       1'b0, op, 1'b0, '0);
         end
         FN_SCALE: u = mk_uop(SRC_A, elem, SRC_SCALAR, '0, 1'b0, ACC_LOAD, 1'b0, '0);
         FN_DET: u = det_uop(term);
         FN_TRACE: u = mk_uop(SRC_A, term << 2, SRC_ONE, '0, 1'b0, op, 1'b0, '0);
         default: u = mk_uop(SRC_A, elem, SRC_ONE, '0, 1'b0, ACC_LOAD, 1'b0, '0);
      endcase
      return u;
   endfunction

endpackage

@@ rtl/core/matrix3x3_arith_unit.sv @@
// Operation: a load writes one element from the idle state; a run goes through the fetch X, fetch Y,
// multiply and accumulate states for each multiply-accumulate step and an emit state per result.
// One item at a time; the next item is taken the cycle after the last result is staged. The single
// 33x33 multiplier and the one operand fetch port are shared by all steps of a run.
// Reset (synchronous, active high) clears both matrices to zero and empties the result stage.
module matrix3x3_arith_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // element_index [3:0], operand_value [35:4], zero [39:36]
   input  logic [m3x3_pkg::REQ_TDATA_WIDTH-1:0]     req_tdata,
   // start_req [0], func [3:1], target_b [4]
   input  logic [m3x3_pkg::REQ_TUSER_WIDTH-1:0]     req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // result_value [31:0], result_index [35:32], zero [39:36]
   output logic [m3x3_pkg::RSP_TDATA_WIDTH-1:0]     rsp_tdata,
   output logic                                     rsp_tlast,
   // saturated [0]
   output logic                                     rsp_tuser
);

   localparam int DW = m3x3_pkg::DATA_WIDTH;

   m3x3_pkg::store_ctl_type              store_ctl;
   m3x3_pkg::mac_ctl_type                mac_ctl;
   m3x3_pkg::emit_type                   emit;
   logic signed [DW-1:0]                 req_value;
   logic signed [DW-1:0]                 a_rd;
   logic signed [DW-1:0]                 b_rd;
   logic signed [DW-1:0]                 sat_value;
   logic                                 sat_flag;
   logic                                 slot_free;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]                        rsp_value_ff, rsp_value_in;
   logic [m3x3_pkg::IDX_WIDTH-1:0]       rsp_index_ff, rsp_index_in;
   logic                                 rsp_last_ff, rsp_last_in;
   logic                                 rsp_sat_ff, rsp_sat_in;

   assign req_value = DW'($signed(req_tdata[m3x3_pkg::REQ_VALUE_LSB +: 32]));
   assign slot_free = !rsp_valid_ff || rsp_tready;

   m3x3_sequencer u_sequencer (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_start    (req_tuser[0]),
      .req_func     (req_tuser[3:1]),
      .req_target_b (req_tuser[4]),
      .req_index    (req_tdata[m3x3_pkg::IDX_WIDTH-1:0]),
      .slot_free    (slot_free),
      .store_ctl    (store_ctl),
      .mac_ctl      (mac_ctl),
      .emit         (emit)
   );

   m3x3_matrix_store u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (store_ctl),
      .wr_data (req_value),
      .a_rd    (a_rd),
      .b_rd    (b_rd)
   );

   m3x3_mac_unit u_mac (
      .clock        (clock),
      .ctl          (mac_ctl),
      .a_rd         (a_rd),
      .b_rd         (b_rd),
      .scalar_value (req_value),
      .sat_value    (sat_value),
      .sat_flag     (sat_flag)
   );

   // result stage: holds one transfer so the core can go on
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = sat_value;
         rsp_index_in = emit.index;
         rsp_last_in  = emit.last;
         rsp_sat_in   = sat_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{m3x3_pkg::RSP_PAD_WIDTH{1'b0}}, rsp_index_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

@@ rtl/core/m3x3_matrix_store.sv @@
module m3x3_matrix_store (
   input  logic                                   clock,
   input  logic                                   reset,
   input  m3x3_pkg::store_ctl_type                ctl,
   input  logic signed [m3x3_pkg::DATA_WIDTH-1:0] wr_data,
   output logic signed [m3x3_pkg::DATA_WIDTH-1:0] a_rd,
   output logic signed [m3x3_pkg::DATA_WIDTH-1:0] b_rd
);

   logic signed [m3x3_pkg::DATA_WIDTH-1:0] a_ff [m3x3_pkg::ELEM_COUNT];
   logic signed [m3x3_pkg::DATA_WIDTH-1:0] a_in [m3x3_pkg::ELEM_COUNT];
   logic signed [m3x3_pkg::DATA_WIDTH-1:0] b_ff [m3x3_pkg::ELEM_COUNT];
   logic signed [m3x3_pkg::DATA_WIDTH-1:0] b_in [m3x3_pkg::ELEM_COUNT];

   // element writes and in-place transpose
   always_comb begin
      for (int k = 0; k < m3x3_pkg::ELEM_COUNT; k++) begin
         a_in[k] = a_ff[k];
         b_in[k] = b_ff[k];
         if (ctl.swap) begin
            a_in[k] = a_ff[m3x3_pkg::transpose_pos(k)];
         end
         if (ctl.wr_en && ctl.wr_addr == m3x3_pkg::IDX_WIDTH'(k)) begin
            if (ctl.wr_b) begin
               b_in[k] = wr_data;
            end else begin
               a_in[k] = wr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < m3x3_pkg::ELEM_COUNT; k++) begin
            a_ff[k] <= '0;
            b_ff[k] <= '0;
         end
      end else begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   // single read port shared by both matrices
   always_comb begin
      a_rd = '0;
      b_rd = '0;
      if (ctl.rd_addr < m3x3_pkg::IDX_WIDTH'(m3x3_pkg::ELEM_COUNT)) begin
         a_rd = a_ff[ctl.rd_addr];
         b_rd = b_ff[ctl.rd_addr];
      end
   end

endmodule

@@ rtl/core/m3x3_mac_unit.sv @@
module m3x3_mac_unit (
   input  logic                                   clock,
   input  m3x3_pkg::mac_ctl_type                  ctl,
   input  logic signed [m3x3_pkg::DATA_WIDTH-1:0] a_rd,
   input  logic signed [m3x3_pkg::DATA_WIDTH-1:0] b_rd,
   input  logic signed [m3x3_pkg::DATA_WIDTH-1:0] scalar_value,
   output logic signed [m3x3_pkg::DATA_WIDTH-1:0] sat_value,
   output logic                                   sat_flag
);

   localparam int DW  = m3x3_pkg::DATA_WIDTH;
   localparam int OPW = m3x3_pkg::OP_WIDTH;
   localparam int PW  = m3x3_pkg::PROD_WIDTH;
   localparam int ACW = m3x3_pkg::ACC_WIDTH;
   localparam int TW  = m3x3_pkg::T_WIDTH;

   logic signed [DW-1:0]  scalar_ff, scalar_in;
   logic signed [OPW-1:0] x_ff, x_in;
   logic signed [OPW-1:0] y_ff, y_in;
   logic signed [PW-1:0]  prod_ff, prod_in;
   logic signed [ACW-1:0] acc_ff, acc_in;
   logic signed [TW-1:0]  t_ff [m3x3_pkg::T_COUNT];
   logic signed [TW-1:0]  t_in [m3x3_pkg::T_COUNT];
   logic signed [TW-1:0]  t_sel;
   logic signed [OPW-1:0] fetch;
   logic signed [ACW-1:0] prod_ext;
   logic signed [ACW-1:0] addend;
   logic                  in_range;

   // operand fetch
   always_comb begin
      case (ctl.fetch_addr[m3x3_pkg::T_ADDR_W-1:0])
         2'd1:    t_sel = t_ff[1];
         2'd2:    t_sel = t_ff[2];
         default: t_sel = t_ff[0];
      endcase
      case (ctl.fetch_src)
         m3x3_pkg::SRC_A:      fetch = OPW'(a_rd);
         m3x3_pkg::SRC_B:      fetch = OPW'(b_rd);
         m3x3_pkg::SRC_SCALAR: fetch = OPW'(scalar_ff);
         m3x3_pkg::SRC_ONE:    fetch = m3x3_pkg::ONE_OPERAND;
         m3x3_pkg::SRC_TLO:    fetch = $signed({1'b0, t_sel[DW-1:0]});
         m3x3_pkg::SRC_THI:    fetch = OPW'($signed(t_sel[TW-1:DW]));
         default:              fetch = '0;
      endcase
   end

   // operand latches and shared multiplier
   always_comb begin
      scalar_in = ctl.scalar_load ? scalar_value : scalar_ff;
      x_in      = ctl.load_x ? fetch : x_ff;
      y_in      = ctl.load_y ? fetch : y_ff;
      prod_in   = ctl.mul_en ? x_ff * y_ff : prod_ff;
   end

   // align product and accumulate; floor shift per product
   always_comb begin
      prod_ext = ACW'(prod_ff);
      addend   = ctl.shift_up ? (prod_ext <<< (DW - m3x3_pkg::FRAC_BITS))
                              : (prod_ext >>> m3x3_pkg::FRAC_BITS);
      acc_in   = acc_ff;
      if (ctl.acc_en) begin
         case (ctl.acc_op)
            m3x3_pkg::ACC_ADD: acc_in = acc_ff + addend;
            m3x3_pkg::ACC_SUB: acc_in = acc_ff - addend;
            default:           acc_in = addend;
         endcase
      end
      for (int k = 0; k < m3x3_pkg::T_COUNT; k++) begin
         t_in[k] = t_ff[k];
         if (ctl.acc_en && ctl.t_store && ctl.t_addr == m3x3_pkg::T_ADDR_W'(k)) begin
            t_in[k] = acc_in[TW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      scalar_ff <= scalar_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      t_ff      <= t_in;
   end

   // clamp to the element range
   always_comb begin
      in_range  = (&acc_ff[ACW-1:DW-1]) || !(|acc_ff[ACW-1:DW-1]);
      sat_flag  = !in_range;
      sat_value = in_range ? acc_ff[DW-1:0]
                           : {acc_ff[ACW-1], {(DW-1){!acc_ff[ACW-1]}}};
   end

endmodule

@@ rtl/core/m3x3_sequencer.sv @@
`include "matrix3x3_arith_unit_macros.svh"

module m3x3_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_start,
   input  logic [2:0]                          req_func,
   input  logic                                req_target_b,
   input  logic [m3x3_pkg::IDX_WIDTH-1:0]      req_index,
   input  logic                                slot_free,
   output m3x3_pkg::store_ctl_type             store_ctl,
   output m3x3_pkg::mac_ctl_type               mac_ctl,
   output m3x3_pkg::emit_type                  emit
);

   m3x3_pkg::state_type                   state_ff, state_in;
   m3x3_pkg::func_type                    func_ff, func_in;
   logic [m3x3_pkg::IDX_WIDTH-1:0]        elem_ff, elem_in;
   logic [m3x3_pkg::IDX_WIDTH-1:0]        term_ff, term_in;
   m3x3_pkg::uop_type                     uop;
   logic                                  fetch_y;

   assign uop     = m3x3_pkg::microcode(func_ff, elem_ff, term_ff);
   assign fetch_y = (state_ff == m3x3_pkg::ST_FETCH_Y);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= m3x3_pkg::ST_IDLE;
         func_ff  <= m3x3_pkg::FN_ADD;
         elem_ff  <= '0;
         term_ff  <= '0;
      end else begin
         state_ff <= state_in;
         func_ff  <= func_in;
         elem_ff  <= elem_in;
         term_ff  <= term_in;
      end
   end

   // next state and step controls
   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      elem_in    = elem_ff;
      term_in    = term_ff;
      req_tready = 1'b0;
      store_ctl  = '0;
      mac_ctl    = '0;
      emit       = '0;

      mac_ctl.fetch_src  = fetch_y ? uop.y_src : uop.x_src;
      mac_ctl.fetch_addr = fetch_y ? uop.y_addr : uop.x_addr;
      mac_ctl.shift_up   = uop.shift_up;
      mac_ctl.acc_op     = uop.acc_op;
      mac_ctl.t_store    = uop.t_store;
      mac_ctl.t_addr     = uop.t_addr;
      store_ctl.rd_addr  = mac_ctl.fetch_addr;
      store_ctl.wr_b     = req_target_b;
      store_ctl.wr_addr  = req_index;
      emit.index         = elem_ff;
      emit.last          = (elem_ff == m3x3_pkg::last_elem(func_ff));

      case (state_ff)
         m3x3_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (!req_start) begin
                  store_ctl.wr_en = (req_index <
                                     m3x3_pkg::IDX_WIDTH'(m3x3_pkg::ELEM_COUNT));
               end else if (req_func <= 3'(m3x3_pkg::FN_TRACE)) begin
                  func_in             = m3x3_pkg::func_type'(req_func);
                  elem_in             = '0;
                  term_in             = '0;
                  mac_ctl.scalar_load = 1'b1;
                  store_ctl.swap      = (req_func == 3'(m3x3_pkg::FN_TRANSPOSE));
                  state_in            = m3x3_pkg::ST_FETCH_X;
               end
            end
         end
         m3x3_pkg::ST_FETCH_X: begin
            mac_ctl.load_x = 1'b1;
            state_in       = m3x3_pkg::ST_FETCH_Y;
         end
         m3x3_pkg::ST_FETCH_Y: begin
            mac_ctl.load_y = 1'b1;
            state_in       = m3x3_pkg::ST_MUL;
         end
         m3x3_pkg::ST_MUL: begin
            mac_ctl.mul_en = 1'b1;
            state_in       = m3x3_pkg::ST_ACC;
         end
         m3x3_pkg::ST_ACC: begin
            mac_ctl.acc_en = 1'b1;
            if (term_ff == m3x3_pkg::last_term(func_ff)) begin
               state_in = m3x3_pkg::ST_EMIT;
            end else begin
               term_in  = term_ff + 1'b1;
               state_in = m3x3_pkg::ST_FETCH_X;
            end
         end
         m3x3_pkg::ST_EMIT: begin
            emit.valid = slot_free;
            if (slot_free) begin
               if (emit.last) begin
                  state_in = m3x3_pkg::ST_IDLE;
               end else begin
                  elem_in  = elem_ff + 1'b1;
                  term_in  = '0;
                  state_in = m3x3_pkg::ST_FETCH_X;
               end
            end
         end
         default: state_in = m3x3_pkg::ST_IDLE;
      endcase
   end

   // a valid start always begins a run
   `M3X3_ASSERT_NEXT(a_start_runs, clock, reset, req_tvalid && req_tready && req_start && (req_func <= 3'(m3x3_pkg::FN_TRACE)), state_ff == m3x3_pkg::ST_FETCH_X, "valid start did not begin a run")
   // step counter stays inside the operation's program
   `M3X3_ASSERT_SAME(a_term_bound, clock, reset, state_ff != m3x3_pkg::ST_IDLE, term_ff <= m3x3_pkg::last_term(func_ff), "step counter past end of program")
   // element counter stays inside the result run
   `M3X3_ASSERT_SAME(a_elem_bound, clock, reset, state_ff != m3x3_pkg::ST_IDLE, elem_ff <= m3x3_pkg::last_elem(func_ff), "element counter past end of run")
   // final result returns the block to idle
   `M3X3_ASSERT_NEXT(a_last_idle, clock, reset, emit.valid && emit.last, state_ff == m3x3_pkg::ST_IDLE, "run did not end after last result")

endmodule

@@ tb/sv/matrix3x3_arith_unit_checker.sv @@
`timescale 1ns / 100ps

// Watches both streams of the 3x3 matrix unit, keeps its own copy of the two
// matrices, works out the owed results of each accepted item and compares them
// with the results the block returns.
module matrix3x3_arith_unit_checker
   import m3x3_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   // element_index [3:0], operand_value [35:4], zero [39:36]
   input  logic [REQ_TDATA_WIDTH-1:0]  req_tdata,
   // start_req [0], func [3:1], target_b [4]
   input  logic [REQ_TUSER_WIDTH-1:0]  req_tuser,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // result_value [31:0], result_index [35:32], zero [39:36]
   input  logic [RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   input  logic                        rsp_tlast,
   // saturated [0]
   input  logic                        rsp_tuser,
   input  logic                        drained,
   output int                          mismatches,
   output int                          results_due,
   output int                          results_seen,
   output int                          clamped_seen
);

   typedef logic signed [DATA_WIDTH-1:0] elem_type;
   typedef logic signed [63:0]           acc64_type;
   typedef logic signed [127:0]          wide_type;

   typedef struct packed {
      elem_type             value;
      logic [IDX_WIDTH-1:0] index;
      logic                 last;
      logic                 clamped;
   } matrix_result_type;

   // 64-bit intermediate range and element range
   localparam wide_type  ACC_MAX  = wide_type'(64'h7FFF_FFFF_FFFF_FFFF);
   localparam wide_type  ACC_MIN  = -ACC_MAX - 1;
   localparam acc64_type ELEM_MAX = (acc64_type'(1) <<< (DATA_WIDTH - 1)) - 1;
   localparam acc64_type ELEM_MIN = -ELEM_MAX - 1;

   elem_type          mat_a [ELEM_COUNT];
   elem_type          mat_b [ELEM_COUNT];
   matrix_result_type results_owed [$];
   matrix_result_type head;
   logic              clamp_hit;
   logic              leftovers_done = 1'b0;

   initial begin
      mismatches   = 0;
      results_due  = 0;
      results_seen = 0;
      clamped_seen = 0;
   end

   // one line per mismatch
   task automatic log_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
      mismatches++;
      $display("%0t: %s: expected %h, got %h", $time, what, want, got);
   endtask

   // clamp to the 64-bit intermediate range
   function automatic acc64_type clamp_acc(input wide_type v);
      if (v > ACC_MAX) begin
         clamp_hit = 1'b1;
         return ACC_MAX[63:0];
      end
      if (v < ACC_MIN) begin
         clamp_hit = 1'b1;
         return ACC_MIN[63:0];
      end
      return v[63:0];
   endfunction

   // exact product, floor shift by the fraction bits
   function automatic acc64_type mul_frac(input acc64_type x, input acc64_type y);
      wide_type p;
      p = wide_type'(x) * wide_type'(y);
      return clamp_acc(p >>> FRAC_BITS);
   endfunction

   function automatic acc64_type add_acc(input acc64_type x, input acc64_type y);
      return clamp_acc(wide_type'(x) + wide_type'(y));
   endfunction

   function automatic acc64_type sub_acc(input acc64_type x, input acc64_type y);
      return clamp_acc(wide_type'(x) - wide_type'(y));
   endfunction

   function automatic elem_type clamp_elem(input acc64_type v);
      if (v > ELEM_MAX) begin
         clamp_hit = 1'b1;
         return ELEM_MAX[DATA_WIDTH-1:0];
      end
      if (v < ELEM_MIN) begin
         clamp_hit = 1'b1;
         return ELEM_MIN[DATA_WIDTH-1:0];
      end
      return v[DATA_WIDTH-1:0];
   endfunction

   // apply one accepted item to the matrix copy and queue what it owes
   task automatic predict_item(input logic [REQ_TUSER_WIDTH-1:0] user,
                               input logic [REQ_TDATA_WIDTH-1:0] data);
      logic [IDX_WIDTH-1:0] pos;
      elem_type             operand;
      elem_type             held;
      func_type             fn;
      acc64_type            acc;
      acc64_type            t0;
      acc64_type            t1;
      acc64_type            t2;
      int                   k;
      int                   row;
      int                   col;
      int                   mirror;
      matrix_result_type    res;

      pos     = data[IDX_WIDTH-1:0];
      operand = data[REQ_VALUE_LSB +: DATA_WIDTH];
      fn      = func_type'(user[3:1]);

      if (!user[0]) begin
         // element load; positions past the matrix are dropped
         if (pos < ELEM_COUNT) begin
            if (user[4]) mat_b[pos] = operand;
            else mat_a[pos] = operand;
         end
      end else begin
         case (fn)
            FN_ADD, FN_SUB, FN_MUL, FN_SCALE, FN_TRANSPOSE: begin
               // transpose rewrites A before it is emitted
               if (fn == FN_TRANSPOSE) begin
                  for (k = 0; k < ELEM_COUNT; k++) begin
                     mirror = (k % 3) * 3 + k / 3;
                     if (k < mirror) begin
                        held          = mat_a[k];
                        mat_a[k]      = mat_a[mirror];
                        mat_a[mirror] = held;
                     end
                  end
               end
               for (k = 0; k < ELEM_COUNT; k++) begin
                  clamp_hit = 1'b0;
                  row = k % 3;
                  col = k / 3;
                  case (fn)
                     FN_ADD: acc = add_acc(mat_a[k], mat_b[k]);
                     FN_SUB: acc = sub_acc(mat_a[k], mat_b[k]);
                     FN_MUL: begin
                        acc = add_acc(add_acc(mul_frac(mat_a[row], mat_b[3 * col]),
                                              mul_frac(mat_a[3 + row], mat_b[3 * col + 1])),
                                      mul_frac(mat_a[6 + row], mat_b[3 * col + 2]));
                     end
                     FN_SCALE: acc = mul_frac(mat_a[k], operand);
                     default:  acc = mat_a[k];
                  endcase
                  res.value   = clamp_elem(acc);
                  res.index   = IDX_WIDTH'(k);
                  res.last    = (k == ELEM_COUNT - 1);
                  res.clamped = clamp_hit;
                  results_owed.push_back(res);
               end
            end
            FN_DET, FN_TRACE: begin
               clamp_hit = 1'b0;
               if (fn == FN_DET) begin
                  // cofactor expansion along the first row
                  t0  = sub_acc(mul_frac(mat_a[4], mat_a[8]), mul_frac(mat_a[5], mat_a[7]));
                  t1  = sub_acc(mul_frac(mat_a[2], mat_a[7]), mul_frac(mat_a[1], mat_a[8]));
                  t2  = sub_acc(mul_frac(mat_a[1], mat_a[5]), mul_frac(mat_a[2], mat_a[4]));
                  acc = add_acc(add_acc(mul_frac(mat_a[0], t0), mul_frac(mat_a[3], t1)),
                                mul_frac(mat_a[6], t2));
               end else begin
                  acc = add_acc(add_acc(mat_a[0], mat_a[4]), mat_a[8]);
               end
               res.value   = clamp_elem(acc);
               res.index   = '0;
               res.last    = 1'b1;
               res.clamped = clamp_hit;
               results_owed.push_back(res);
            end
            default: ;  // unused code, no result
         endcase
      end
   endtask

   // result check, then prediction of a newly accepted item
   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ELEM_COUNT; k++) begin
            mat_a[k] = '0;
            mat_b[k] = '0;
         end
         results_owed.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (results_owed.size() == 0) begin
               log_mismatch("result transfer with nothing owed", '0,
                            rsp_tdata[DATA_WIDTH-1:0]);
            end else begin
               head = results_owed.pop_front();
               results_seen++;
               if (rsp_tuser) clamped_seen++;
               if (rsp_tdata[DATA_WIDTH-1:0] !== head.value) begin
                  log_mismatch($sformatf("value of element %0d", head.index),
                               head.value, rsp_tdata[DATA_WIDTH-1:0]);
               end
               if (rsp_tdata[DATA_WIDTH +: IDX_WIDTH] !== head.index) begin
                  log_mismatch("element index", 32'(head.index),
                               32'(rsp_tdata[DATA_WIDTH +: IDX_WIDTH]));
               end
               if (rsp_tlast !== head.last) begin
                  log_mismatch($sformatf("last mark of element %0d", head.index),
                               32'(head.last), 32'(rsp_tlast));
               end
               if (rsp_tuser !== head.clamped) begin
                  log_mismatch($sformatf("clamp flag of element %0d", head.index),
                               32'(head.clamped), 32'(rsp_tuser));
               end
            end
         end
         if (req_tvalid && req_tready) predict_item(req_tuser, req_tdata);
         // anything still owed once the stream has drained never arrived
         if (drained && !leftovers_done) begin
            leftovers_done = 1'b1;
            while (results_owed.size() != 0) begin
               head = results_owed.pop_front();
               log_mismatch($sformatf("element %0d never arrived", head.index),
                            head.value, '0);
            end
         end
      end
      results_due = results_owed.size();
   end

endmodule

@@ tb/sv/matrix3x3_arith_unit_tb.sv @@
`timescale 1ns / 100ps

module matrix3x3_arith_unit_tb;
   import m3x3_pkg::*;

   localparam int         CLOCK_HALF      = 10;
   localparam int         RESET_CYCLES    = 11;
   localparam int         CYCLE_LIMIT     = 1_000_000;
   localparam int         HOLD_OFF_CYCLES = 600;
   localparam int         DRAIN_CYCLES    = 150;
   localparam int         PHASE_ITEMS     = 100;
   localparam logic [2:0] FN_RESERVED     = 3'd7;
   localparam logic [31:0] Q_ONE   = 32'h0001_0000;
   localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] VAL_MIN = 32'h8000_0000;

   typedef enum int {
      OPND_WIDE,
      OPND_SMALL,
      OPND_EDGE,
      OPND_MID
   } operand_kind_t;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_TDATA_WIDTH-1:0]  req_tdata  = '0;
   logic [REQ_TUSER_WIDTH-1:0]  req_tuser  = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0]  rsp_tdata;
   logic                        rsp_tlast;
   logic                        rsp_tuser;
   logic                        drained     = 1'b0;
   logic                        hold_off    = 1'b0;
   logic                        hold_off_go = 1'b0;

   int mismatches;
   int results_due;
   int results_seen;
   int clamped_seen;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int items_done     = 0;
   int loads_done     = 0;
   int loads_ignored  = 0;
   int runs_per_func [8];
   int cycle_count    = 0;
   int held_cycles;
   int send_plan [4]  = '{0, 81, 0, 37};
   int recv_plan [4]  = '{0, 0, 81, 37};

   matrix3x3_arith_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   matrix3x3_arith_unit_checker op_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser),
      .drained      (drained),
      .mismatches   (mismatches),
      .results_due  (results_due),
      .results_seen (results_seen),
      .clamped_seen (clamped_seen)
   );

   // 20 ns clock
   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // result side: random stalls, or a solid hold-off
   always @(posedge clock) begin
      rsp_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // long receiver hold-off, counted here so the sender keeps offering
   initial begin
      @(posedge hold_off_go);
      hold_off <= 1'b1;
      for (held_cycles = 0; held_cycles < HOLD_OFF_CYCLES; held_cycles++) @(posedge clock);
      hold_off <= 1'b0;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timed out after %0d cycles with %0d results owed", cycle_count, results_due);
      $display("matrix3x3_arith_unit: mismatch");
      $finish;
   end

   // offer one item and hold it until the transfer
   task automatic push_item(input logic start, input logic [2:0] fn, input logic to_b,
                            input logic [IDX_WIDTH-1:0] pos, input logic [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_WIDTH'({value, pos});
      req_tuser  <= {to_b, fn, start};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (!start) begin
         if (pos < ELEM_COUNT) begin
            loads_done++;
            items_done++;
         end else begin
            loads_ignored++;
         end
      end else begin
         runs_per_func[fn]++;
         if (fn != FN_RESERVED) items_done++;
      end
   endtask

   // func is a don't-care on a load, so it is randomized
   task automatic load_elem(input logic to_b, input logic [IDX_WIDTH-1:0] pos,
                            input logic [31:0] value);
      push_item(1'b0, 3'($urandom_range(7)), to_b, pos, value);
   endtask

   // target and index are don't-cares on a run
   task automatic run_op(input logic [2:0] fn, input logic [31:0] scalar);
      push_item(1'b1, fn, 1'($urandom_range(1)), 4'($urandom_range(15)), scalar);
   endtask

   function automatic operand_kind_t pick_kind();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40) return OPND_SMALL;
      if (roll < 60) return OPND_MID;
      if (roll < 80) return OPND_WIDE;
      return OPND_EDGE;
   endfunction

   // Q16.16 operand of the given flavor
   function automatic logic [31:0] rand_operand(input operand_kind_t kind);
      case (kind)
         OPND_WIDE:  return $urandom();
         OPND_SMALL: return 32'($urandom_range(32'h0010_0000)) - 32'h0008_0000;
         OPND_MID:   return 32'($urandom_range(32'h0200_0000)) - 32'h0100_0000;
         default: begin
            case ($urandom_range(6))
               0:       return VAL_MAX;
               1:       return VAL_MIN;
               2:       return '0;
               3:       return Q_ONE;
               4:       return -Q_ONE;
               5:       return 32'd1;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   // mostly a few loads and a run; sometimes stray loads or the unused code
   task automatic random_sequence();
      operand_kind_t kind;
      int            roll;
      int            n;
      kind = pick_kind();
      roll = $urandom_range(99);
      if (roll < 85) begin
         n = $urandom_range(9);
         repeat (n) load_elem(1'($urandom_range(1)), 4'($urandom_range(8)), rand_operand(kind));
         run_op(3'($urandom_range(6)), rand_operand(kind));
      end else if (roll < 90) begin
         load_elem(1'($urandom_range(1)), 4'($urandom_range(15, 9)), rand_operand(kind));
      end else if (roll < 93) begin
         run_op(FN_RESERVED, $urandom());
      end else if (roll < 97) begin
         load_elem(1'($urandom_range(1)), 4'($urandom_range(8)), rand_operand(kind));
      end else begin
         run_op(3'($urandom_range(6)), rand_operand(kind));
      end
   endtask

   initial begin
      int phase_start;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: zero matrices, extreme elements, every operation
      run_op(FN_TRACE, '0);
      load_elem(1'b0, 4'd0, VAL_MAX);
      load_elem(1'b0, 4'd1, 32'h0002_8000);
      load_elem(1'b0, 4'd2, 32'hFFFF_FFFF);
      load_elem(1'b0, 4'd3, -Q_ONE);
      load_elem(1'b0, 4'd4, VAL_MIN);
      load_elem(1'b0, 4'd5, 32'h0003_0000);
      load_elem(1'b0, 4'd6, 32'd3);
      load_elem(1'b0, 4'd7, 32'h7FFF_0000);
      load_elem(1'b0, 4'd8, Q_ONE);
      load_elem(1'b1, 4'd0, VAL_MAX);
      load_elem(1'b1, 4'd4, 32'd1);
      load_elem(1'b1, 4'd8, 32'hFFFF_FFFF);
      // positions past the matrix leave it alone
      load_elem(1'b0, 4'd15, 32'h5555_5555);
      load_elem(1'b1, 4'd9, 32'hAAAA_AAAA);
      run_op(FN_ADD, '0);
      run_op(FN_SUB, '0);
      run_op(FN_MUL, '0);
      run_op(FN_SCALE, VAL_MIN);
      run_op(FN_SCALE, VAL_MAX);
      run_op(FN_TRANSPOSE, '0);
      run_op(FN_DET, '0);
      run_op(FN_TRACE, '0);
      run_op(FN_RESERVED, '0);

      // pressure: receiver holds off while runs keep coming
      hold_off_go <= 1'b1;
      repeat (4) begin
         load_elem(1'($urandom_range(1)), 4'($urandom_range(8)), rand_operand(OPND_SMALL));
         run_op(3'($urandom_range(6)), rand_operand(OPND_SMALL));
      end

      // random phases under each idle pattern
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_plan[p];
         recv_stall_pct = recv_plan[p];
         phase_start    = items_done;
         while (items_done - phase_start < PHASE_ITEMS) random_sequence();
      end

      // drain
      req_tvalid     <= 1'b0;
      recv_stall_pct = 0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      drained <= 1'b1;
      repeat (2) @(posedge clock);

      $display("covered %0d element loads (%0d past the matrix); runs add %0d sub %0d mul %0d",
               loads_done, loads_ignored, runs_per_func[FN_ADD], runs_per_func[FN_SUB],
               runs_per_func[FN_MUL]);
      $display("scale %0d transpose %0d det %0d trace %0d unused %0d; %0d results, %0d clamped",
               runs_per_func[FN_SCALE], runs_per_func[FN_TRANSPOSE], runs_per_func[FN_DET],
               runs_per_func[FN_TRACE], runs_per_func[FN_RESERVED], results_seen, clamped_seen);
      if (mismatches == 0) begin
         $display("matrix3x3_arith_unit: match");
      end else begin
         $display("matrix3x3_arith_unit: mismatch");
      end
      $finish;
   end

endmodule
